### rtl/llra_pkg.sv
// Shared types, constants and helpers for the level loop reduction block.
// Used by llra_ctrl, llra_dp and level_loop_reduction_adjust; depends on nothing.
`default_nettype none

package llra_pkg;

  localparam int IN_W     = 128;  // 122 payload bits, padded to whole bytes
  localparam int OUT_W    = 144;
  localparam int CFG_W    = 31;
  localparam int CFG_AW   = 1;
  localparam int LVL_W    = 32;
  localparam int DIST_W   = 31;
  localparam int RAM_W    = 1 + LVL_W + DIST_W;
  localparam int DIV_STEPS = 64;
  localparam int DIV_CW   = 6;

  localparam logic [CFG_AW-1:0] CFG_START_LEVEL = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_END_LEVEL   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;      // accept one point
    logic latch_m;   // register misclosure and its magnitude
    logic mul_en;    // load product register
    logic mul_sel;   // 0: setup correction, 1: distance correction
    logic div_load;  // load divider from product
    logic div_step;  // one quotient bit
    logic save_s;    // hold setup correction
    logic form;      // build result beat
    logic next;      // advance to next stored point
    logic clear;     // drop loop state
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic emit_last;
  } sts_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/llra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module llra_ram #(
  parameter int W = 64,
  parameter int D = 64
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/llra_ctrl.sv
// Sequencer for load and emission phases of the level loop reduction block.
// Depends on llra_pkg (cmd_t, sts_t).
`default_nettype none

module llra_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  input  wire logic          in_last,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output llra_pkg::cmd_t     cmd,
  input  wire llra_pkg::sts_t sts
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_READ = 10'b00_0000_0010,
    ST_MULS = 10'b00_0000_0100,
    ST_LDS  = 10'b00_0000_1000,
    ST_DIVS = 10'b00_0001_0000,
    ST_MULD = 10'b00_0010_0000,
    ST_LDD  = 10'b00_0100_0000,
    ST_DIVD = 10'b00_1000_0000,
    ST_FORM = 10'b01_0000_0000,
    ST_OUT  = 10'b10_0000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.latch_m = 1'b1;
        state_next  = ST_MULS;
      end
      ST_MULS: begin
        cmd.mul_en = 1'b1;
        state_next = ST_LDS;
      end
      ST_LDS: begin
        cmd.div_load = 1'b1;
        state_next   = ST_DIVS;
      end
      ST_DIVS: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_MULD;
      end
      ST_MULD: begin
        cmd.save_s  = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = 1'b1;
        state_next  = ST_LDD;
      end
      ST_LDD: begin
        cmd.div_load = 1'b1;
        cmd.mul_sel  = 1'b1;
        state_next   = ST_DIVD;
      end
      ST_DIVD: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_FORM;
      end
      ST_FORM: begin
        cmd.form   = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (sts.emit_last) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            cmd.next   = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/llra_dp.sv
// Datapath: loop accumulators, point store, multiplier, shared restoring
// divider and result register. Depends on llra_pkg and llra_ram.
`default_nettype none

module llra_dp #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [llra_pkg::CFG_AW-1:0]   cfg_addr,
  input  wire logic [llra_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic [llra_pkg::IN_W-1:0]     in_data,
  input  wire llra_pkg::cmd_t                cmd,
  output llra_pkg::sts_t                     sts,
  output logic      [llra_pkg::OUT_W-1:0]    out_data,
  output logic                               out_last
);

  localparam int IW  = $clog2(MAX_POINTS);
  localparam int PCW = $clog2(MAX_POINTS + 1);

  // input fields
  logic               bv, fv, ev;
  logic [19:0]        br, fr;
  logic [23:0]        bd, fd;
  logic signed [30:0] el;

  assign bv = in_data[0];
  assign br = in_data[20:1];
  assign fv = in_data[21];
  assign fr = in_data[41:22];
  assign bd = in_data[65:42];
  assign fd = in_data[89:66];
  assign ev = in_data[90];
  assign el = $signed(in_data[121:91]);

  logic signed [30:0] start_level, end_level;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_level <= '0;
      end_level   <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        llra_pkg::CFG_START_LEVEL: start_level <= $signed(cfg_data);
        llra_pkg::CFG_END_LEVEL:   end_level   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // loop state
  logic [PCW-1:0]     point_count, rise_count;
  logic [19:0]        prev_back;
  logic               prev_ok, run_ok;
  logic signed [31:0] running;
  logic [27:0]        sum_bh, sum_fh;
  logic [30:0]        sum_bd, sum_fd;
  logic [IW-1:0]      k;

  logic               full, store, rise;
  logic signed [20:0] dh;
  logic signed [31:0] running_next;
  logic               run_ok_next;
  logic [30:0]        cum_next, total;

  assign full  = (point_count == PCW'(MAX_POINTS));
  assign store = cmd.load && !full;
  assign rise  = prev_ok && fv;
  assign dh    = $signed({1'b0, prev_back}) - $signed({1'b0, fr});
  assign cum_next = sum_fd + 31'(fd) + sum_bd;
  assign total    = sum_fd + sum_bd;

  always_comb begin
    if (rise && run_ok) begin
      running_next = running + 32'(dh);
      run_ok_next  = 1'b1;
    end else if (point_count == '0) begin
      running_next = 32'(start_level);
      run_ok_next  = 1'b1;
    end else if (ev) begin
      running_next = 32'(el);
      run_ok_next  = 1'b1;
    end else begin
      running_next = '0;
      run_ok_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      point_count <= '0;
      rise_count  <= '0;
      prev_back   <= '0;
      prev_ok     <= 1'b0;
      running     <= '0;
      run_ok      <= 1'b0;
      sum_bh      <= '0;
      sum_fh      <= '0;
      sum_bd      <= '0;
      sum_fd      <= '0;
      k           <= '0;
    end else begin
      if (store) begin
        if (bv) sum_bh <= sum_bh + 28'(br);
        if (fv) sum_fh <= sum_fh + 28'(fr);
        if (rise) rise_count <= rise_count + PCW'(1);
        sum_fd      <= sum_fd + 31'(fd);
        sum_bd      <= sum_bd + 31'(bd);
        running     <= running_next;
        run_ok      <= run_ok_next;
        prev_back   <= bv ? br : 20'd0;
        prev_ok     <= bv;
        point_count <= point_count + PCW'(1);
      end
      if (cmd.next) k <= k + IW'(1);
    end
  end

  // point store: {level ok, level, cumulative distance}
  logic [llra_pkg::RAM_W-1:0] rdata;

  llra_ram #(.W(llra_pkg::RAM_W), .D(MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (point_count[IW-1:0]),
    .wdata ({run_ok_next, running_next, cum_next}),
    .raddr (k),
    .rdata (rdata)
  );

  logic               lv_ok;
  logic signed [31:0] lv;
  logic [30:0]        cum_k;

  assign lv_ok = rdata[63];
  assign lv    = $signed(rdata[62:31]);
  assign cum_k = rdata[30:0];

  // misclosure
  logic signed [32:0] m_comb, m_reg;
  logic [31:0]        mag;

  assign m_comb = (33'(start_level) - 33'(end_level))
                - ($signed({5'b0, sum_fh}) - $signed({5'b0, sum_bh}));

  always_ff @(posedge clk) begin
    if (cmd.latch_m) begin
      m_reg <= m_comb;
      mag   <= m_comb[32] ? 32'(-m_comb) : m_comb[31:0];
    end
  end

  // multiply then divide
  logic [30:0] op_b;
  logic [62:0] prod;
  logic [30:0] den;
  logic [31:0] dd;
  logic [63:0] nq;
  logic [31:0] rem;
  logic [llra_pkg::DIV_CW-1:0] cnt;
  logic [32:0] rem_sh;
  logic        qbit;

  assign op_b = cmd.mul_sel ? cum_k : 31'(k);
  assign den  = cmd.mul_sel ? total : 31'(rise_count);

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= {31'b0, mag} * {32'b0, op_b};
    end
  end

  assign rem_sh = {rem, nq[63]};
  assign qbit   = (rem_sh >= {1'b0, dd});

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dd  <= {den, 1'b0};
      nq  <= {prod, 1'b0} + 64'(den);
      rem <= '0;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= qbit ? 32'(rem_sh - {1'b0, dd}) : rem_sh[31:0];
      nq  <= {nq[62:0], qbit};
      cnt <= cnt + llra_pkg::DIV_CW'(1);
    end
  end

  assign sts.div_last  = (cnt == llra_pkg::DIV_CW'(llra_pkg::DIV_STEPS - 1));
  assign sts.emit_last = (PCW'(k) + PCW'(1) == point_count);

  // the numerator is -m times the operand: its sign is the opposite of m
  logic signed [33:0] corr_cur, cs, cd;
  logic [32:0]        q_mag;
  logic               serr, derr;

  // a quotient past 33 bits saturates every adjusted level anyway: clip it
  assign q_mag    = (|nq[63:33]) ? '1 : nq[32:0];
  assign corr_cur = m_reg[32] ? $signed({1'b0, q_mag}) : -$signed({1'b0, q_mag});
  assign serr     = (rise_count == '0);
  assign derr     = (total == '0);
  assign cd       = derr ? '0 : corr_cur;

  always_ff @(posedge clk) begin
    if (cmd.save_s) cs <= serr ? '0 : corr_cur;
  end

  logic signed [31:0] rl, ls, ld;

  assign rl = lv_ok ? lv : '0;
  assign ls = lv_ok ? llra_pkg::sat32(35'(lv) + 35'(cs)) : '0;
  assign ld = lv_ok ? llra_pkg::sat32(35'(lv) + 35'(cd)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.form) begin
      out_data <= {derr, serr, 7'(rise_count), llra_pkg::sat32(35'(m_reg)),
                   ld, ls, rl, lv_ok, 6'(k)};
      out_last <= sts.emit_last;
    end
  end

endmodule

`default_nettype wire

### rtl/level_loop_reduction_adjust.sv
// Top level of the level loop reduction and misclosure adjustment block.
// Depends on llra_pkg, llra_ctrl, llra_dp (and llra_ram through llra_dp).
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata (one levelling point), s_tlast
// m_*       out  m_tvalid/m_tready  m_tdata (one adjusted point), m_tlast
// cfg_*     in   cfg_we             cfg_addr, cfg_data (start/end level)
//
// Load: one point per cycle while s_tready is high; s_tready drops after the
// beat carrying s_tlast until the last result beat has been taken.
// Emission: each result is computed in turn by the shared
// restoring divider (one quotient bit per cycle, run once per correction).
// A stalled result holds in the output register until m_tready.
// Reset (rst, synchronous) clears FSM, config and loop state; the point store
// needs no clearing pass, only entries of the current loop are read.
module level_loop_reduction_adjust #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [llra_pkg::CFG_AW-1:0]    cfg_addr,
  input  wire logic [llra_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // back_valid, back_reading, fore_valid, fore_reading, back_distance,
  // fore_distance, elev_valid, elevation, zero pad (lowest bit first)
  input  wire logic [llra_pkg::IN_W-1:0]      s_tdata,
  input  wire logic                           s_tlast,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // point_index, level_valid, reduced_level, level_by_setup,
  // level_by_distance, misclosure, setup_count, setup_error,
  // distance_error (lowest bit first)
  output logic      [llra_pkg::OUT_W-1:0]     m_tdata,
  output logic                                m_tlast
);

  llra_pkg::cmd_t cmd;
  llra_pkg::sts_t sts;

  // sequencer: owns the handshakes, steps the datapath
  llra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_last   (s_tlast),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // accumulators, store, multiplier, divider, result register
  llra_dp #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_data  (s_tdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (m_tdata),
    .out_last (m_tlast)
  );

  // loading and emitting never overlap
  a_phase_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is shown");

  // the closing point starts emission
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("load continued after closing point");

  // the final result beat returns the block to loading
  a_final_beat_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not ready for a new loop after the final beat");

  // each further result needs a new multiply and divide pass
  a_gap_between_results: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> !m_tvalid)
    else $error("result shown without a correction pass");

endmodule

`default_nettype wire
